### design/reassembly_context_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reassembly context table unit
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef REASSEMBLY_CONTEXT_TABLE_UNIT_MACROS_SVH
`define REASSEMBLY_CONTEXT_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("reassembly context table check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("reassembly context table check failed");

`endif

### design/rct_pkg.sv
// ----------------------------------------------------------------------------
// Reassembly context table package
// Types, codes and constants shared by the controller, datapath and checker.
// ----------------------------------------------------------------------------
package rct_pkg;

    localparam int unsigned SLOTS_DEF = 8;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned IDENT_W   = 16;
    localparam int unsigned STAMP_W   = 48;
    localparam int unsigned TIMEOUT_W = 32;
    localparam int unsigned MASK_W    = 8;
    localparam int unsigned SLOT_W    = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd60000;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_SWEEP  = 1'b1;

    localparam logic [1:0] OUT_MATCH   = 2'd0;
    localparam logic [1:0] OUT_ALLOC   = 2'd1;
    localparam logic [1:0] OUT_REPLACE = 2'd2;
    localparam logic [1:0] OUT_SWEEP   = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [ADDR_W-1:0]  source_address;
        logic [ADDR_W-1:0]  destination_address;
        logic [IDENT_W-1:0] datagram_ident;
        logic [STAMP_W-1:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [1:0]        outcome;
        logic [MASK_W-1:0] expired_mask;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0]  source;
        logic [ADDR_W-1:0]  destination;
        logic [IDENT_W-1:0] ident;
    } t_key;

    typedef struct packed {
        t_key               key;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
    } t_status;

endpackage

### design/rct_ctrl.sv
// ----------------------------------------------------------------------------
// Reassembly context table controller
// Sequences request capture, the slot scan and the final commit.
// ----------------------------------------------------------------------------
module rct_ctrl import rct_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

### design/rct_dpath.sv
// ----------------------------------------------------------------------------
// Reassembly context table datapath
// Context memory, valid bits, scan accumulators and the result register.
// ----------------------------------------------------------------------------
module rct_dpath import rct_pkg::*; #(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_req                 i_req,
    input  logic                 i_cfg_we,
    input  logic [TIMEOUT_W-1:0] i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic                 o_done,
    output t_rsp                 o_rsp
);

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS + 1);

    logic [TIMEOUT_W-1:0] r_timeout;
    t_req                 r_req;
    t_entry               r_mem [SLOTS];
    t_entry               r_rd_data;
    logic [CW-1:0]        r_cnt;
    logic [SLOTS-1:0]     r_valid;
    logic [SLOTS-1:0]     n_valid;
    logic                 r_found;
    logic [AW-1:0]        r_match_idx;
    logic                 r_have_free;
    logic [AW-1:0]        r_free_idx;
    logic [STAMP_W-1:0]   r_old_stamp;
    logic [AW-1:0]        r_old_idx;
    logic [SLOTS-1:0]     r_cleared;
    logic                 r_done;
    t_rsp                 r_rsp;

    logic [CW-1:0]        cnt_m1;
    logic [AW-1:0]        e_idx;
    logic                 eval;
    logic                 rd_en;
    logic                 e_valid;
    t_key                 req_key;
    logic                 key_hit;
    logic [STAMP_W-1:0]   age;
    logic                 expire;
    logic                 is_sweep;
    logic [AW-1:0]        pick;
    logic [1:0]           pick_outcome;
    logic [AW+2:0]        pick_pad;
    logic [SLOTS+7:0]     cleared_pad;

    assign cnt_m1   = r_cnt - CW'(1);
    assign e_idx    = cnt_m1[AW-1:0];
    // The entry read in the previous cycle is judged while the next one is read.
    assign eval     = i_cmd.step && (r_cnt != '0);
    assign rd_en    = i_cmd.step && (r_cnt < CW'(SLOTS));
    assign is_sweep = (r_req.operation == OP_SWEEP);

    assign req_key.source      = r_req.source_address;
    assign req_key.destination = r_req.destination_address;
    assign req_key.ident       = r_req.datagram_ident;

    assign e_valid = r_valid[e_idx];
    assign key_hit = e_valid && (r_rd_data.key == req_key);
    assign age     = r_req.now_ms - r_rd_data.stamp;
    assign expire  = e_valid && (age > {{(STAMP_W-TIMEOUT_W){1'b0}}, r_timeout});

    always_comb begin
        if (r_found) begin
            pick         = r_match_idx;
            pick_outcome = OUT_MATCH;
        end else if (r_have_free) begin
            pick         = r_free_idx;
            pick_outcome = OUT_ALLOC;
        end else begin
            pick         = r_old_idx;
            pick_outcome = OUT_REPLACE;
        end
    end

    // Slot numbers and the cleared mask are reported in an eight-slot view.
    assign pick_pad    = {3'b000, pick};
    assign cleared_pad = {8'h00, r_cleared};

    always_comb begin
        n_valid = r_valid;
        if (eval && is_sweep && expire) begin
            n_valid[e_idx] = 1'b0;
        end
        if (i_cmd.commit && !is_sweep) begin
            n_valid[pick] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_valid   <= '0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            r_valid <= n_valid;
            r_done  <= i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req       <= i_req;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_cleared   <= '0;
        end
        if (i_cmd.step) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (eval) begin
            if (!r_found && key_hit) begin
                r_found     <= 1'b1;
                r_match_idx <= e_idx;
            end
            if (!r_have_free && !e_valid) begin
                r_have_free <= 1'b1;
                r_free_idx  <= e_idx;
            end
            // Strictly smaller keeps the lowest index on equal stamps.
            if ((e_idx == '0) || (r_rd_data.stamp < r_old_stamp)) begin
                r_old_stamp <= r_rd_data.stamp;
                r_old_idx   <= e_idx;
            end
            if (is_sweep && expire) begin
                r_cleared[e_idx] <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            if (is_sweep) begin
                r_rsp.slot         <= '0;
                r_rsp.outcome      <= OUT_SWEEP;
                r_rsp.expired_mask <= cleared_pad[7:0];
            end else begin
                r_rsp.slot         <= pick_pad[2:0];
                r_rsp.outcome      <= pick_outcome;
                r_rsp.expired_mask <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !is_sweep) begin
            r_mem[pick] <= {req_key, r_req.now_ms};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_cnt[AW-1:0]];
        end
    end

    assign o_status.scan_last = (r_cnt == CW'(SLOTS));
    assign o_done             = r_done;
    assign o_rsp              = r_rsp;

endmodule

### design/reassembly_context_table_unit.sv
// ----------------------------------------------------------------------------
// Reassembly context table unit
// Finds, allocates or ages out fragment reassembly contexts.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge where start is high and busy is low.
//   Operation lookup matches the key against valid slots, else claims the
//   lowest free slot, else replaces the slot with the smallest stamp; the
//   chosen slot gets the request time as its stamp. Operation sweep clears
//   every valid slot older than the timeout and reports them in a mask.
//   The timeout register is written through i_cfg_we and i_cfg_data; the
//   user must do so only while the unit is idle; the unit does not enforce it.
//   Each request gives one result, shown for one cycle with o_done high
//   from the result register and done flag loaded in the commit state.
//   The scan reads one slot of the context memory per cycle, and busy
//   stays high through the scan and commit states, so a new request is
//   taken only once the unit is back in idle after the commit state.
//   Reset marks every slot free and loads a timeout of 60000 ms.
//   The receiver has no way to stall; each result must be taken as shown.
// ----------------------------------------------------------------------------
module reassembly_context_table_unit import rct_pkg::*; #(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_req                 i_req,
    output logic                 busy,
    output logic                 o_done,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [TIMEOUT_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    rct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    rct_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

endmodule

### design/rct_checker.sv
// ----------------------------------------------------------------------------
// Reassembly context table checker
// Port-level checks on request timing and result field consistency.
// ----------------------------------------------------------------------------
`include "reassembly_context_table_unit_macros.svh"

module rct_checker import rct_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_rsp o_rsp
);

    logic sweep_done;
    logic lookup_done;

    assign sweep_done  = o_done && (o_rsp.outcome == OUT_SWEEP);
    assign lookup_done = o_done && (o_rsp.outcome != OUT_SWEEP);

    // An accepted request keeps the unit busy while it scans.
    `RCT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // A result only appears once the unit is back to idle.
    `RCT_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy)

    // Sweep results always report slot zero.
    `RCT_ASSERT_SAME(a_sweep_slot, i_clk, i_rst_n, sweep_done, o_rsp.slot == '0)

    // Lookup results never carry expired slots.
    `RCT_ASSERT_SAME(a_lookup_mask, i_clk, i_rst_n, lookup_done, o_rsp.expired_mask == '0)

endmodule

bind reassembly_context_table_unit rct_checker u_rct_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
